>>> rtl/core/graphic_lcd_write_sequencer_top_defines.svh
// Assertion macros for the LCD write sequencer.
// Expects clock and reset in scope at the point of use.
`ifndef GRAPHIC_LCD_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define GRAPHIC_LCD_WRITE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCDWS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCDWS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/lcdws_pkg.sv
// Shared types, constants and byte tables for the LCD write sequencer.
// No dependencies; used by every module of the block.
package lcdws_pkg;

   localparam int ROW_WIDTH_DEFAULT   = 128;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] FIRST_COL      = 8'd11;
   localparam logic [5:0] CONTRAST_RESET = 6'd25;
   localparam logic [4:0] PAGE_CMD_BASE  = 5'b10110;  // 176 + page
   localparam logic [7:0] COL_HIGH_CMD   = 8'd16;
   localparam int         CSR_ADDR_W     = 3;
   localparam logic       CSR_IDX_CONTRAST = 1'b0;
   localparam logic [3:0] INIT_LAST_STEP = 4'd11;
   localparam logic [3:0] INIT_CONTRAST_STEP = 4'd5;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_HOME  = 2'd1,
      CMD_INIT  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      JOB_WRITE = 2'd0,
      JOB_ADDR  = 2'd1,
      JOB_INIT  = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic         wrap;
      logic [2:0]   page;
      logic [7:0]   data;
   } job_type;

   typedef struct packed {
      logic       full;
      logic       empty;
   } queue_status_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } beat_type;

   // Fixed controller setup; the contrast slot is filled in by the caller.
   function automatic logic [7:0] init_byte(input logic [3:0] idx);
      logic [7:0] b;
      case (idx)
         4'd0:    b = 8'd226;
         4'd1:    b = 8'd161;
         4'd2:    b = 8'd163;
         4'd3:    b = 8'h2f;
         4'd4:    b = 8'd129;
         4'd6:    b = 8'd175;
         4'd7:    b = 8'd197;
         4'd8:    b = 8'd200;
         4'd9:    b = 8'd64;
         4'd10:   b = 8'd176;
         4'd11:   b = 8'd16;
         default: b = 8'd0;
      endcase
      return b;
   endfunction

   // Page / column address triple.
   function automatic logic [7:0] addr_byte(input logic [1:0] idx, input logic [2:0] page);
      logic [7:0] b;
      case (idx)
         2'd0:    b = {PAGE_CMD_BASE, page};
         2'd1:    b = COL_HIGH_CMD;
         default: b = FIRST_COL;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/graphic_lcd_write_sequencer_top.sv
// Top level of the graphic LCD write sequencer: CSR port, front end,
// job queue and back end. Depends on lcdws_pkg and the defines header.
//
//   channel   dir   handshake          payload
//   req_*     in    tvalid / tready    tdata: command, data_byte
//   rsp_*     out   tvalid / tready    tdata: bus_byte, tuser: is_data, tlast: last
//   csr_*     in    psel / penable     contrast register at byte address 0
//
// Flow: a command is taken whenever the job queue has room; the back end
// sends one bus byte per cycle while rsp_tready holds, so a write without
// wrap costs one bus byte, a write with wrap four, home three and init
// twelve. The back end's single byte per cycle sets the sustained rate; the
// first byte passes a queue slot and then the output register before rsp.
// Reset: contrast 25, cursor at column 11, page 0,
// queue empty. A stalled rsp side fills the queue, then drops req_tready.
`include "graphic_lcd_write_sequencer_top_defines.svh"

module graphic_lcd_write_sequencer_top #(
   parameter int ROW_WIDTH   = lcdws_pkg::ROW_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = lcdws_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // req transaction
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,   // [1:0] command, [9:2] data_byte
   // rsp transaction
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] bus_byte
   output logic                            rsp_tuser,   // [0] is_data
   output logic                            rsp_tlast,
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lcdws_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [5:0]                    contrast_ff, contrast_in;
   logic                          csr_hit;
   logic                          req_accept;
   logic                          push;
   logic                          pop;
   lcdws_pkg::job_type            push_job;
   lcdws_pkg::job_type            head_job;
   lcdws_pkg::queue_status_type   q_status;
   lcdws_pkg::beat_type           out_beat;

   // Configuration: one register; ignore writes beyond it.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == lcdws_pkg::CSR_IDX_CONTRAST);
   assign csr_prdata = csr_hit ? {26'd0, contrast_ff} : 32'd0;

   always_comb begin
      contrast_in = contrast_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         contrast_in = csr_pwdata[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         contrast_ff <= lcdws_pkg::CONTRAST_RESET;
      end else begin
         contrast_ff <= contrast_in;
      end
   end

   // Hold off new commands only when the queue is full.
   assign req_tready = !q_status.full;
   assign req_accept = req_tvalid && req_tready;

   lcdws_front #(
      .ROW_WIDTH (ROW_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .command   (req_tdata[1:0]),
      .data_byte (req_tdata[9:2]),
      .push      (push),
      .push_job  (push_job)
   );

   lcdws_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   lcdws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .contrast  (contrast_ff),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (out_beat)
   );

   assign rsp_tdata = out_beat.bus_byte;
   assign rsp_tuser = out_beat.is_data;
   assign rsp_tlast = out_beat.last;

   // Never retire a job from an empty queue.
   `LCDWS_ASSERT_IMP(a_pop_nonempty, pop, !q_status.empty, "job popped from empty queue")
   // A queued job is visible in the next cycle.
   `LCDWS_ASSERT_NXT(a_push_visible, push, !q_status.empty, "accepted command lost")
   // The closing byte of an init job is a marked command byte.
   `LCDWS_ASSERT_NXT(a_init_no_data,
      pop && (head_job.kind == lcdws_pkg::JOB_INIT), !out_beat.is_data && out_beat.last,
      "init job produced data byte")

endmodule

>>> rtl/core/lcdws_front.sv
// Front end: accepts commands, tracks the cursor, classifies into jobs.
// Depends on lcdws_pkg.
module lcdws_front #(
   parameter int ROW_WIDTH = lcdws_pkg::ROW_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          command,
   input  logic [7:0]          data_byte,
   output logic                push,
   output lcdws_pkg::job_type  push_job
);

   localparam logic [7:0] COL_END = 8'(int'(lcdws_pkg::FIRST_COL) + ROW_WIDTH);

   logic [7:0] column_ff, column_in;
   logic [2:0] page_ff, page_in;
   logic [7:0] col_plus;
   logic       wrap;

   assign col_plus = column_ff + 8'd1;
   assign wrap     = (col_plus == COL_END);

   always_comb begin
      column_in     = column_ff;
      page_in       = page_ff;
      push          = 1'b0;
      push_job.kind = lcdws_pkg::JOB_WRITE;
      push_job.wrap = 1'b0;
      push_job.page = page_ff;
      push_job.data = data_byte;
      if (accept) begin
         case (command)
            lcdws_pkg::CMD_WRITE: begin
               push          = 1'b1;
               push_job.wrap = wrap;
               if (wrap) begin
                  column_in = lcdws_pkg::FIRST_COL;
                  page_in   = page_ff + 3'd1;
               end else begin
                  column_in = col_plus;
               end
               push_job.page = page_in;
            end
            lcdws_pkg::CMD_HOME: begin
               push          = 1'b1;
               push_job.kind = lcdws_pkg::JOB_ADDR;
               column_in     = lcdws_pkg::FIRST_COL;
               page_in       = 3'd0;
               push_job.page = 3'd0;
            end
            lcdws_pkg::CMD_INIT: begin
               push          = 1'b1;
               push_job.kind = lcdws_pkg::JOB_INIT;
            end
            default: begin
               // drop the unused code
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= lcdws_pkg::FIRST_COL;
         page_ff   <= 3'd0;
      end else begin
         column_ff <= column_in;
         page_ff   <= page_in;
      end
   end

endmodule

>>> rtl/core/lcdws_queue.sv
// Short job queue between the front and back ends.
// Depends on lcdws_pkg.
module lcdws_queue #(
   parameter int DEPTH = lcdws_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lcdws_pkg::job_type            push_job,
   input  logic                          pop,
   output lcdws_pkg::job_type            head_job,
   output lcdws_pkg::queue_status_type   status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lcdws_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head_job     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/core/lcdws_back.sv
// Back end: expands the head job into bus bytes, one per cycle while the
// output is not stalled, into an output register. Depends on lcdws_pkg.
module lcdws_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lcdws_pkg::job_type            head_job,
   input  lcdws_pkg::queue_status_type   q_status,
   input  logic [5:0]                    contrast,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output lcdws_pkg::beat_type           out_beat
);

   logic [3:0]          step_ff, step_in;
   logic                valid_ff, valid_in;
   lcdws_pkg::beat_type beat_ff;
   lcdws_pkg::beat_type beat;
   logic                advance;
   logic [3:0]          addr_idx;

   assign advance  = !q_status.empty && (!valid_ff || out_ready);
   assign addr_idx = (head_job.kind == lcdws_pkg::JOB_WRITE) ? step_ff - 4'd1 : step_ff;

   always_comb begin
      beat.is_data  = 1'b0;
      beat.bus_byte = lcdws_pkg::addr_byte(addr_idx[1:0], head_job.page);
      beat.last     = (addr_idx == 4'd2);
      case (head_job.kind)
         lcdws_pkg::JOB_WRITE: begin
            if (step_ff == 4'd0) begin
               beat.is_data  = 1'b1;
               beat.bus_byte = head_job.data;
               beat.last     = !head_job.wrap;
            end
         end
         lcdws_pkg::JOB_ADDR: begin
            // address triple already selected
         end
         lcdws_pkg::JOB_INIT: begin
            beat.bus_byte = (step_ff == lcdws_pkg::INIT_CONTRAST_STEP) ?
                            {2'b00, contrast} : lcdws_pkg::init_byte(step_ff);
            beat.last     = (step_ff == lcdws_pkg::INIT_LAST_STEP);
         end
         default: begin
            beat.last = 1'b1;
         end
      endcase
   end

   assign pop = advance && beat.last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
         step_in  = beat.last ? 4'd0 : step_ff + 4'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         beat_ff <= beat;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

>>> sim/tb_graphic_lcd_write_sequencer_top.sv
// Testbench for the graphic LCD write sequencer: streams commands in, predicts every
// bus byte with its own cursor/contrast model, and checks each rsp transaction in order.
// Depends on lcdws_pkg and the graphic_lcd_write_sequencer_top RTL.
`timescale 1ns / 1ps

module tb_graphic_lcd_write_sequencer_top;

   // Row width as the block is built by default.
   localparam int          ROW_W         = lcdws_pkg::ROW_WIDTH_DEFAULT;
   localparam int          QUIET_CYCLES  = 24;       // longest run (init) plus pipeline
   localparam int          HOLD_CYCLES   = 200;      // long receiver hold-off
   localparam longint      LIMIT_NS      = 3_000_000;
   localparam logic [7:0]  PAGE_CMD      = 8'd176;
   localparam logic [7:0]  COL_HIGH      = 8'd16;
   localparam int          CONTRAST_SLOT = 5;
   localparam logic [2:0]  ADDR_CONTRAST = 3'd0;
   localparam logic [2:0]  ADDR_NO_REG   = 3'd4;     // register index 1: not implemented
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam logic [7:0]  SETUP_SEQ [12] = '{8'd226, 8'd161, 8'd163, 8'h2f, 8'd129, 8'd0,
                                              8'd175, 8'd197, 8'd200, 8'd64, 8'd176, 8'd16};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // [1:0] command, [9:2] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] bus_byte
   logic        rsp_tuser;         // [0] is_data
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [lcdws_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state: cursor, contrast register and the bytes still owed by the block.
   logic [7:0]  cur_column = lcdws_pkg::FIRST_COL;
   logic [2:0]  cur_page = 3'd0;
   logic [5:0]  contrast_reg = lcdws_pkg::CONTRAST_RESET;
   lcdws_pkg::beat_type pending_beats[$];
   int          mismatch_count = 0;

   // Traffic shaping: idle_en for sender and receiver, hold_kick for the receiver.
   logic        idle_en = 1'b1;
   logic        hold_kick = 1'b0;

   graphic_lcd_write_sequencer_top #(
      .ROW_WIDTH(ROW_W)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Byte predictor
   // ---------------------------------------------------------------------------------

   function automatic void owe_beat(input logic is_data, input logic [7:0] b,
                                    input logic last);
      lcdws_pkg::beat_type beat;
      beat.is_data  = is_data;
      beat.bus_byte = b;
      beat.last     = last;
      pending_beats.push_back(beat);
   endfunction

   // Page/column address triple that follows a wrap or a home.
   function automatic void owe_address();
      owe_beat(1'b0, PAGE_CMD + {5'd0, cur_page}, 1'b0);
      owe_beat(1'b0, COL_HIGH, 1'b0);
      owe_beat(1'b0, lcdws_pkg::FIRST_COL, 1'b1);
   endfunction

   // Advance the cursor model for one accepted command and queue the bytes it causes.
   function automatic void predict_lcd_bytes(input logic [1:0] cmd, input logic [7:0] data);
      logic wrap;
      case (cmd)
         lcdws_pkg::CMD_WRITE: begin
            wrap = (cur_column == lcdws_pkg::FIRST_COL + ROW_W - 1);
            owe_beat(1'b1, data, !wrap);
            if (wrap) begin
               cur_column = lcdws_pkg::FIRST_COL;
               cur_page   = cur_page + 3'd1;   // wraps from 7 to 0 by width
               owe_address();
            end else begin
               cur_column = cur_column + 8'd1;
            end
         end
         lcdws_pkg::CMD_HOME: begin
            cur_column = lcdws_pkg::FIRST_COL;
            cur_page   = 3'd0;
            owe_address();
         end
         lcdws_pkg::CMD_INIT: begin
            for (int i = 0; i < 12; i++)
               owe_beat(1'b0, (i == CONTRAST_SLOT) ? {2'b00, contrast_reg} : SETUP_SEQ[i],
                        i == 11);
         end
         default: ;   // unused code: no bytes, cursor untouched
      endcase
   endfunction

   // ---------------------------------------------------------------------------------
   // Receiver: check each rsp transaction, stall in bursts, honor long hold-offs
   // ---------------------------------------------------------------------------------

   int   stall_left = 0;
   int   hold_left = 0;
   logic hold_seen = 1'b0;

   always @(posedge clock) begin
      lcdws_pkg::beat_type want;
      // Values read here are the ones sampled at this edge.
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected rsp transaction: byte %02h is_data %0b last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tdata !== want.bus_byte) begin
               $display("%0t: bus_byte mismatch: expected %02h actual %02h",
                        $time, want.bus_byte, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.is_data) begin
               $display("%0t: is_data mismatch: expected %0b actual %0b",
                        $time, want.is_data, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last mismatch: expected %0b actual %0b",
                        $time, want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
      // Start a long hold-off whenever the test flips the kick bit.
      if (hold_kick != hold_seen) begin
         hold_seen = hold_kick;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 7);   // this cycle counts as the first
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender and CSR tasks; every task starts and ends just after a rising edge
   // ---------------------------------------------------------------------------------

   // Offer one command, optionally after an idle burst; predict on acceptance.
   task automatic send_command(input logic [1:0] cmd, input logic [7:0] data);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, data, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_lcd_bytes(cmd, data);
   endtask

   task automatic send_write();
      send_command(lcdws_pkg::CMD_WRITE, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)      send_command(lcdws_pkg::CMD_WRITE, 8'($urandom_range(0, 255)));
      else if (r < 84) send_command(lcdws_pkg::CMD_HOME, 8'($urandom_range(0, 255)));
      else if (r < 93) send_command(lcdws_pkg::CMD_INIT, 8'($urandom_range(0, 255)));
      else             send_command(CMD_UNUSED, 8'($urandom_range(0, 255)));
   endtask

   // Drop valid, wait for every owed byte, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (addr == ADDR_CONTRAST) contrast_reg = value[5:0];
   endtask

   task automatic csr_check_contrast();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_CONTRAST;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== {26'd0, contrast_reg}) begin
         $display("%0t: contrast readback mismatch: expected %08h actual %08h",
                  $time, {26'd0, contrast_reg}, csr_prdata);
         mismatch_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Reset defaults, data extremes, home, the unused code.
   task automatic test_directed_commands();
      csr_check_contrast();
      send_command(lcdws_pkg::CMD_INIT, 8'h00);   // reset contrast in the setup run
      send_command(lcdws_pkg::CMD_WRITE, 8'h00);
      send_command(lcdws_pkg::CMD_WRITE, 8'hff);
      send_command(CMD_UNUSED, 8'hff);            // ignored, cursor unchanged
      send_command(lcdws_pkg::CMD_WRITE, 8'h5a);
      send_command(lcdws_pkg::CMD_HOME, 8'hff);
      send_command(lcdws_pkg::CMD_WRITE, 8'h81);
      drain();
   endtask

   // Contrast at both ends, a write to a missing register, readback each time.
   task automatic test_contrast_extremes();
      csr_write(ADDR_CONTRAST, 32'd0);
      csr_check_contrast();
      send_command(lcdws_pkg::CMD_INIT, 8'h00);
      drain();
      csr_write(ADDR_CONTRAST, 32'hffff_ffff);   // upper bits must be dropped
      csr_check_contrast();
      send_command(lcdws_pkg::CMD_INIT, 8'h00);
      drain();
      csr_write(ADDR_NO_REG, $urandom);
      csr_check_contrast();
      send_command(lcdws_pkg::CMD_INIT, 8'h00);
      drain();
   endtask

   // Hold the receiver off while writes keep coming, so req_tready must drop.
   task automatic test_backpressure();
      hold_kick <= ~hold_kick;
      repeat (16) send_write();
      drain();
   endtask

   // Keep writing until the cursor runs off the end of the row, then a few more.
   task automatic test_row_wrap();
      logic [2:0] start_page;
      start_page = cur_page;
      while (cur_page == start_page) send_write();
      repeat (2) send_write();
      drain();
   endtask

   // Mixed traffic with a random contrast setting.
   task automatic test_random_traffic();
      csr_write(ADDR_CONTRAST, $urandom);
      repeat (6) send_random_command();
      drain();
   endtask

   // Full rate on both sides.
   task automatic test_back_to_back();
      idle_en <= 1'b0;
      repeat (8) send_random_command();
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_commands();
      test_contrast_extremes();
      test_backpressure();
      test_row_wrap();
      test_random_traffic();
      test_back_to_back();

      if (mismatch_count == 0)
         $display("tb_graphic_lcd_write_sequencer_top OK");
      else
         $display("tb_graphic_lcd_write_sequencer_top NOT OK");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #(LIMIT_NS);
      $display("tb_graphic_lcd_write_sequencer_top NOT OK");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lcdws_pkg.sv
rtl/core/lcdws_front.sv
rtl/core/lcdws_queue.sv
rtl/core/lcdws_back.sv
rtl/core/graphic_lcd_write_sequencer_top.sv
sim/tb_graphic_lcd_write_sequencer_top.sv
